/* src/fatba_pkg.sv */
`timescale 1ns / 1ps
// Package for the file-allocation-table block allocator.
// Holds sizes, operation and status codes, directory types and the format function.
// No dependencies.
package fatba_pkg;

  localparam int NUM_BLOCKS      = 256;
  localparam int ROOT_ENTRIES    = 8;
  localparam int RESERVED_BLOCKS = 13;

  localparam int BLK_W  = 8;
  localparam int CNT_W  = BLK_W + 1;
  localparam int DIR_W  = 3;
  localparam int NAME_W = 40;
  localparam int MODE_W = 3;
  localparam int STAT_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_CREATE = 3'd0,
    MODE_REMOVE = 3'd1,
    MODE_APPEND = 3'd2,
    MODE_DELETE = 3'd3,
    MODE_CHECK  = 3'd4,
    MODE_NEXT   = 3'd5,
    MODE_FIRST  = 3'd6
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 3'd0,
    ST_EXISTS      = 3'd1,
    ST_DIR_FULL    = 3'd2,
    ST_NOT_FOUND   = 3'd3,
    ST_NOT_EMPTY   = 3'd4,
    ST_DISK_FULL   = 3'd5,
    ST_NOT_IN_FILE = 3'd6,
    ST_FILE_EMPTY  = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    DIR_NONE   = 2'd0,
    DIR_CREATE = 2'd1,
    DIR_REMOVE = 2'd2,
    DIR_FIRST  = 2'd3
  } dir_op_e;

  typedef struct packed {
    dir_op_e          op;
    logic [DIR_W-1:0] idx;
    logic [BLK_W-1:0] first;
  } dir_upd_t;

  typedef struct packed {
    logic             hit;
    logic [DIR_W-1:0] hit_idx;
    logic [BLK_W-1:0] hit_first;
    logic             free_hit;
    logic [DIR_W-1:0] free_idx;
  } dir_look_t;

  // Link value written to each entry by the format pass after reset.
  function automatic logic [BLK_W-1:0] fmt_link(input logic [BLK_W-1:0] idx);
    int i;
    int data0;
    i     = int'(idx);
    data0 = RESERVED_BLOCKS + 1;
    if (i == 0) begin
      return (data0 < NUM_BLOCKS) ? BLK_W'(data0) : '0;
    end else if (i >= data0 && i + 1 < NUM_BLOCKS) begin
      return BLK_W'(i + 1);
    end
    return '0;
  endfunction

endpackage

/* src/fatba_if.sv */
`timescale 1ns / 1ps
// Handshake channels of the allocator: request and response.
// Depends on fatba_pkg.
interface fatba_req_if import fatba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [NAME_W-1:0] file_name;
  logic [BLK_W-1:0]  block_number;

  modport source (output valid, mode, file_name, block_number, input ready);
  modport sink (input valid, mode, file_name, block_number, output ready);
endinterface

interface fatba_rsp_if import fatba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [BLK_W-1:0]  block_value;

  modport source (output valid, status, block_value, input ready);
  modport sink (input valid, status, block_value, output ready);
endinterface

/* src/fatba_dir.sv */
`timescale 1ns / 1ps
// Root directory of the allocator: slot registers, name lookup and free-slot search.
// Depends on fatba_pkg.
module fatba_dir import fatba_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [NAME_W-1:0] name_i,
  input  dir_upd_t          upd_i,
  output dir_look_t         look_o
);

  logic [NAME_W-1:0] names_q [ROOT_ENTRIES];
  logic              used_q  [ROOT_ENTRIES];
  logic [BLK_W-1:0]  first_q [ROOT_ENTRIES];

  // Lowest matching slot and lowest free slot win.
  always_comb begin
    look_o = '0;
    for (int i = ROOT_ENTRIES - 1; i >= 0; i--) begin
      if (used_q[i] && names_q[i] == name_i) begin
        look_o.hit     = 1'b1;
        look_o.hit_idx = DIR_W'(i);
      end
      if (!used_q[i]) begin
        look_o.free_hit = 1'b1;
        look_o.free_idx = DIR_W'(i);
      end
    end
    look_o.hit_first = first_q[look_o.hit_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROOT_ENTRIES; i++) begin
        names_q[i] <= '0;
        used_q[i]  <= 1'b0;
        first_q[i] <= '0;
      end
    end else begin
      unique case (upd_i.op)
        DIR_CREATE: begin
          used_q[upd_i.idx]  <= 1'b1;
          names_q[upd_i.idx] <= name_i;
          first_q[upd_i.idx] <= '0;
        end
        DIR_REMOVE: begin
          used_q[upd_i.idx]  <= 1'b0;
          names_q[upd_i.idx] <= '0;
        end
        DIR_FIRST: begin
          first_q[upd_i.idx] <= upd_i.first;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* src/fat_chain_block_allocator_top.sv */
`timescale 1ns / 1ps
// Top level of the file-allocation-table block allocator.
// Depends on fatba_pkg, fatba_req_if / fatba_rsp_if and fatba_dir.
//
// Usage: a request transfer on req_i carries an operation (create, remove,
// append block, delete block, check block, next block, first block), a
// five-character file name and a block number. Every request produces
// exactly one response transfer on rsp_o with a status and a block value.
// Requests are handled one at a time: req_i.ready is high only while the
// engine is idle.
//
// Timing: directory-only operations (create, remove, first) go from the
// dispatch state straight to the done state. Append, delete, check and
// next follow the file's block chain through the link memory at one link per
// cycle, so the response time grows with the number of links read; the walk is
// bounded by NUM_BLOCKS links, and the single read port of the link memory sets
// the walk rate. A new request can be taken in the cycle after the response
// is loaded into the output register.
//
// Reset: after rst_ni is released the engine formats the link memory in a
// pass over all NUM_BLOCKS entries (free chain over the data blocks, reserved
// blocks zero); no request is taken during that pass.
//
// Stall: the response sits in an output register. If the receiver holds
// rsp_o.ready low, the finished result waits there and the engine holds
// in its done state until the register frees up.
module fat_chain_block_allocator_top import fatba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  fatba_req_if.sink   req_i,
  fatba_rsp_if.source rsp_o
);

  // One-hot engine state.
  typedef enum logic [12:0] {
    S_FMT      = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_DISP     = 13'b0000000000100,
    S_APP_HEAD = 13'b0000000001000,
    S_APP_POP  = 13'b0000000010000,
    S_APP_CLR  = 13'b0000000100000,
    S_WALK     = 13'b0000001000000,
    S_DEL_LINK = 13'b0000010000000,
    S_DEL_FREE = 13'b0000100000000,
    S_DEL_TOP  = 13'b0001000000000,
    S_NEXT_VAL = 13'b0010000000000,
    S_DONE     = 13'b0100000000000,
    S_SPARE    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // Latched request.
  logic [MODE_W-1:0] mode_q;
  logic [NAME_W-1:0] name_q;
  logic [BLK_W-1:0]  bn_q;

  // Working registers.
  logic [DIR_W-1:0] e_q, e_d;
  logic [BLK_W-1:0] first_q, first_d;
  logic [BLK_W-1:0] alloc_q, alloc_d;
  logic [BLK_W-1:0] cur_q, cur_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             head_q, head_d;
  logic [BLK_W-1:0] fmt_q, fmt_d;
  logic [STAT_W-1:0] res_status_q, res_status_d;
  logic [BLK_W-1:0]  res_value_q, res_value_d;

  // Output register.
  logic              rsp_valid_q, rsp_valid_d;
  logic [STAT_W-1:0] rsp_status_q, rsp_status_d;
  logic [BLK_W-1:0]  rsp_value_q, rsp_value_d;

  // Link memory: one write and one read per cycle, registered read data.
  logic [BLK_W-1:0] link_mem [NUM_BLOCKS];
  logic             mem_we;
  logic [BLK_W-1:0] mem_wa, mem_wd, mem_ra, mem_rd_q;

  dir_upd_t  dir_upd;
  dir_look_t dir_look;

  logic req_fire;
  logic load_rsp;
  logic walk_more;

  assign req_fire = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.block_value = rsp_value_q;

  fatba_dir u_dir (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .name_i (name_q),
    .upd_i  (dir_upd),
    .look_o (dir_look)
  );

  // A read of the entry being written in the same cycle returns the new data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    mem_rd_q <= (mem_we && mem_wa == mem_ra) ? mem_wd : link_mem[mem_ra];
  end

  // The walk continues while the bound is not spent and the link is not the end.
  assign walk_more = !cnt_q[CNT_W-1] && mem_rd_q != '0;

  assign load_rsp = (state_q == S_DONE) && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    state_d      = state_q;
    e_d          = e_q;
    first_d      = first_q;
    alloc_d      = alloc_q;
    cur_d        = cur_q;
    cnt_d        = cnt_q;
    head_d       = head_q;
    fmt_d        = fmt_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    mem_we       = 1'b0;
    mem_wa       = '0;
    mem_wd       = '0;
    mem_ra       = '0;
    dir_upd      = '0;

    unique case (state_q)
      S_FMT: begin
        mem_we = 1'b1;
        mem_wa = fmt_q;
        mem_wd = fmt_link(fmt_q);
        fmt_d  = fmt_q + 1'b1;
        if (fmt_q == BLK_W'(NUM_BLOCKS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_fire) begin
          state_d = S_DISP;
        end
      end

      S_DISP: begin
        res_status_d = ST_OK;
        res_value_d  = '0;
        e_d          = dir_look.hit_idx;
        first_d      = dir_look.hit_first;
        cur_d        = dir_look.hit_first;
        cnt_d        = '0;
        state_d      = S_DONE;
        if (mode_q == MODE_CREATE) begin
          if (dir_look.hit) begin
            res_status_d = ST_EXISTS;
          end else if (dir_look.free_hit) begin
            dir_upd.op  = DIR_CREATE;
            dir_upd.idx = dir_look.free_idx;
          end else begin
            res_status_d = ST_DIR_FULL;
          end
        end else if (mode_q <= MODE_FIRST && !dir_look.hit) begin
          res_status_d = ST_NOT_FOUND;
        end else begin
          case (mode_q)
            MODE_REMOVE: begin
              if (dir_look.hit_first != '0) begin
                res_status_d = ST_NOT_EMPTY;
              end else begin
                dir_upd.op  = DIR_REMOVE;
                dir_upd.idx = dir_look.hit_idx;
              end
            end
            MODE_APPEND: begin
              mem_ra  = '0;
              state_d = S_APP_HEAD;
            end
            MODE_DELETE: begin
              if (dir_look.hit_first == '0) begin
                res_status_d = ST_FILE_EMPTY;
              end else if (dir_look.hit_first == bn_q) begin
                head_d  = 1'b1;
                mem_ra  = bn_q;
                state_d = S_DEL_LINK;
              end else begin
                head_d  = 1'b0;
                mem_ra  = dir_look.hit_first;
                state_d = S_WALK;
              end
            end
            MODE_CHECK, MODE_NEXT: begin
              if (dir_look.hit_first == '0) begin
                res_status_d = ST_FILE_EMPTY;
              end else if (dir_look.hit_first == bn_q) begin
                if (mode_q == MODE_NEXT) begin
                  mem_ra  = bn_q;
                  state_d = S_NEXT_VAL;
                end
              end else begin
                mem_ra  = dir_look.hit_first;
                state_d = S_WALK;
              end
            end
            MODE_FIRST: begin
              res_value_d = dir_look.hit_first;
            end
            default: begin
            end
          endcase
        end
      end

      S_APP_HEAD: begin
        if (mem_rd_q == '0) begin
          res_status_d = ST_DISK_FULL;
          state_d      = S_DONE;
        end else begin
          alloc_d = mem_rd_q;
          mem_ra  = mem_rd_q;
          state_d = S_APP_POP;
        end
      end

      S_APP_POP: begin
        // The free list head moves on to the block after the allocated one.
        mem_we  = 1'b1;
        mem_wa  = '0;
        mem_wd  = mem_rd_q;
        state_d = S_APP_CLR;
      end

      S_APP_CLR: begin
        mem_we      = 1'b1;
        mem_wa      = alloc_q;
        mem_wd      = '0;
        res_value_d = alloc_q;
        if (first_q == '0) begin
          dir_upd.op    = DIR_FIRST;
          dir_upd.idx   = e_q;
          dir_upd.first = alloc_q;
          state_d       = S_DONE;
        end else begin
          mem_ra  = first_q;
          state_d = S_WALK;
        end
      end

      S_WALK: begin
        // mem_rd_q holds the link of cur_q.
        state_d = S_DONE;
        case (mode_q)
          MODE_APPEND: begin
            if (walk_more) begin
              state_d = S_WALK;
            end else begin
              mem_we = 1'b1;
              mem_wa = cur_q;
              mem_wd = alloc_q;
            end
          end
          MODE_DELETE: begin
            if (walk_more && mem_rd_q != bn_q) begin
              state_d = S_WALK;
            end else if (mem_rd_q != bn_q || bn_q == '0) begin
              res_status_d = ST_NOT_IN_FILE;
            end else begin
              mem_ra  = bn_q;
              state_d = S_DEL_LINK;
            end
          end
          default: begin
            if (!walk_more) begin
              res_status_d = ST_NOT_IN_FILE;
            end else if (mem_rd_q == bn_q) begin
              if (mode_q == MODE_NEXT) begin
                mem_ra  = bn_q;
                state_d = S_NEXT_VAL;
              end
            end else begin
              state_d = S_WALK;
            end
          end
        endcase
        if (state_d == S_WALK) begin
          cur_d  = mem_rd_q;
          cnt_d  = cnt_q + 1'b1;
          mem_ra = mem_rd_q;
        end
      end

      S_DEL_LINK: begin
        // Splice the block out: its successor goes to the file head or to prev.
        if (head_q) begin
          dir_upd.op    = DIR_FIRST;
          dir_upd.idx   = e_q;
          dir_upd.first = mem_rd_q;
        end else begin
          mem_we = 1'b1;
          mem_wa = cur_q;
          mem_wd = mem_rd_q;
        end
        mem_ra  = '0;
        state_d = S_DEL_FREE;
      end

      S_DEL_FREE: begin
        mem_we  = 1'b1;
        mem_wa  = bn_q;
        mem_wd  = mem_rd_q;
        state_d = S_DEL_TOP;
      end

      S_DEL_TOP: begin
        mem_we  = 1'b1;
        mem_wa  = '0;
        mem_wd  = bn_q;
        state_d = S_DONE;
      end

      S_NEXT_VAL: begin
        res_value_d = mem_rd_q;
        state_d     = S_DONE;
      end

      S_DONE: begin
        if (load_rsp) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d  = rsp_valid_q;
    rsp_status_d = rsp_status_q;
    rsp_value_d  = rsp_value_q;
    if (load_rsp) begin
      rsp_valid_d  = 1'b1;
      rsp_status_d = res_status_q;
      rsp_value_d  = (res_status_q == ST_OK) ? res_value_q : '0;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FMT;
      fmt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fmt_q       <= fmt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      mode_q <= req_i.mode;
      name_q <= req_i.file_name;
      bn_q   <= req_i.block_number;
    end
    e_q          <= e_d;
    first_q      <= first_d;
    alloc_q      <= alloc_d;
    cur_q        <= cur_d;
    cnt_q        <= cnt_d;
    head_q       <= head_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    rsp_status_q <= rsp_status_d;
    rsp_value_q  <= rsp_value_d;
  end

  // A failed operation never reports a block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_status_q != ST_OK |-> rsp_value_q == '0)
    else $error("nonzero block value with error status");

  // The link memory is left alone while the engine waits for a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q != S_IDLE && state_q != S_DONE)
    else $error("link memory written while idle");

  // An accepted request is dispatched in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q == S_DISP)
    else $error("request not dispatched");

endmodule

/* verif/tb_fat_chain_block_allocator_top.sv */
`timescale 1ns / 1ps
// Testbench for the file-allocation-table block allocator top level.
// Depends on fatba_pkg, the request/response interfaces and the top level RTL.
// A directory and link-table model predicts every response, and the responses
// are compared in order.
module tb_fat_chain_block_allocator_top;
  import fatba_pkg::*;

  typedef struct packed {
    mode_e             mode;
    logic [NAME_W-1:0] file_name;
    logic [BLK_W-1:0]  block_number;
  } fat_req_t;

  typedef struct packed {
    status_e          status;
    logic [BLK_W-1:0] block_value;
  } fat_rsp_t;

  logic clk_i;
  logic rst_ni;

  fatba_req_if req_if ();
  fatba_rsp_if rsp_if ();

  fat_chain_block_allocator_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // Shadow copy of the allocator state.
  logic [BLK_W-1:0]  fat_link [NUM_BLOCKS];
  logic [NAME_W-1:0] dir_name [ROOT_ENTRIES];
  logic              dir_used [ROOT_ENTRIES];
  logic [BLK_W-1:0]  dir_first[ROOT_ENTRIES];

  fat_req_t pending_reqs[$];
  fat_rsp_t expected_rsps[$];
  int       mismatch_count = 0;
  bit       rsp_hold = 0;
  logic [NAME_W-1:0] name_pool[6];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The format state after reset: reserved blocks zero, data blocks chained.
  function automatic void format_disk();
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      if (i >= RESERVED_BLOCKS + 1 && i + 1 < NUM_BLOCKS) fat_link[i] = BLK_W'(i + 1);
      else fat_link[i] = '0;
    end
    fat_link[0] = BLK_W'(RESERVED_BLOCKS + 1);
    for (int i = 0; i < ROOT_ENTRIES; i++) begin
      dir_name[i] = '0;
      dir_used[i] = 1'b0;
      dir_first[i] = '0;
    end
  endfunction

  // True when blk is reached by walking the chain from first; walks are bounded.
  function automatic bit chain_holds(logic [BLK_W-1:0] first, logic [BLK_W-1:0] blk);
    logic [BLK_W-1:0] cur;
    cur = first;
    if (cur == blk) return 1;
    for (int n = 0; n < NUM_BLOCKS && fat_link[cur] != 0; n++) begin
      cur = fat_link[cur];
      if (cur == blk) return 1;
    end
    return 0;
  endfunction

  // Applies one request to the shadow state and returns the response it gives.
  function automatic fat_rsp_t apply_fat_op(fat_req_t r);
    fat_rsp_t         res;
    int               e;
    logic [BLK_W-1:0] alloc, cur, prev, bn, first;
    res = '{ST_OK, '0};
    bn = r.block_number;
    e = -1;
    for (int i = ROOT_ENTRIES - 1; i >= 0; i--)
      if (dir_used[i] && dir_name[i] == r.file_name) e = i;
    if (r.mode == MODE_CREATE) begin
      if (e >= 0) res.status = ST_EXISTS;
      else begin
        res.status = ST_DIR_FULL;
        for (int i = 0; i < ROOT_ENTRIES; i++) begin
          if (!dir_used[i]) begin
            dir_used[i] = 1'b1;
            dir_name[i] = r.file_name;
            dir_first[i] = '0;
            res.status = ST_OK;
            break;
          end
        end
      end
    end else if (e < 0) begin
      // An unused mode value reports success even without a matching file.
      if (r.mode <= MODE_FIRST) res.status = ST_NOT_FOUND;
    end else begin
      first = dir_first[e];
      case (r.mode)
        MODE_REMOVE: begin
          if (first != 0) res.status = ST_NOT_EMPTY;
          else begin
            dir_used[e] = 1'b0;
            dir_name[e] = '0;
          end
        end
        MODE_APPEND: begin
          alloc = fat_link[0];
          if (alloc == 0) res.status = ST_DISK_FULL;
          else begin
            fat_link[0] = fat_link[alloc];
            fat_link[alloc] = '0;
            if (first == 0) dir_first[e] = alloc;
            else begin
              cur = first;
              for (int n = 0; n < NUM_BLOCKS && fat_link[cur] != 0; n++) cur = fat_link[cur];
              fat_link[cur] = alloc;
            end
            res.block_value = alloc;
          end
        end
        MODE_DELETE: begin
          if (first == 0) res.status = ST_FILE_EMPTY;
          else if (first == bn) begin
            dir_first[e] = fat_link[bn];
            fat_link[bn] = fat_link[0];
            fat_link[0] = bn;
          end else begin
            prev = first;
            for (int n = 0; n < NUM_BLOCKS && fat_link[prev] != bn && fat_link[prev] != 0; n++)
              prev = fat_link[prev];
            if (fat_link[prev] != bn || bn == 0) res.status = ST_NOT_IN_FILE;
            else begin
              fat_link[prev] = fat_link[bn];
              fat_link[bn] = fat_link[0];
              fat_link[0] = bn;
            end
          end
        end
        MODE_CHECK, MODE_NEXT: begin
          if (first == 0) res.status = ST_FILE_EMPTY;
          else if (!chain_holds(first, bn)) res.status = ST_NOT_IN_FILE;
          else if (r.mode == MODE_NEXT) res.block_value = fat_link[bn];
        end
        MODE_FIRST: res.block_value = first;
        default: ;
      endcase
    end
    return res;
  endfunction

  // Queues one request; the prediction is made when the block accepts it.
  task automatic push_req(mode_e m, logic [NAME_W-1:0] nm, logic [BLK_W-1:0] bn);
    fat_req_t r;
    r.mode = m;
    r.file_name = nm;
    r.block_number = bn;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // Gap length: mostly none or short, sometimes long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Request driver. A transfer happens when valid and ready are both high
  // at the edge; the next item is placed in the same nonblocking assignment.
  int src_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.mode <= '0;
      req_if.file_name <= '0;
      req_if.block_number <= '0;
      src_gap = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_rsps.insert(expected_rsps.size(),
                             apply_fat_op(fat_req_t'({req_if.mode, req_if.file_name,
                                                      req_if.block_number})));
        src_gap = gap_len();
      end
      if (!req_if.valid || req_if.ready) begin
        if (src_gap > 0 || pending_reqs.size() == 0) begin
          if (src_gap > 0) src_gap--;
          req_if.valid <= 1'b0;
        end else begin
          fat_req_t r;
          r = pending_reqs.pop_front();
          req_if.valid <= 1'b1;
          req_if.mode <= r.mode;
          req_if.file_name <= r.file_name;
          req_if.block_number <= r.block_number;
        end
      end
    end
  end

  // Response monitor with random back-pressure; rsp_hold forces a long stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response transfer with nothing expected: status=%0d value=%0d",
                 rsp_if.status, rsp_if.block_value);
          mismatch_count++;
        end else begin
          fat_rsp_t exp_rsp;
          exp_rsp = expected_rsps.pop_front();
          if (rsp_if.status !== exp_rsp.status) begin
            $error("status: expected %0d actual %0d", exp_rsp.status, rsp_if.status);
            mismatch_count++;
          end
          if (rsp_if.block_value !== exp_rsp.block_value) begin
            $error("block_value: expected %0d actual %0d", exp_rsp.block_value,
                   rsp_if.block_value);
            mismatch_count++;
          end
        end
      end
      rsp_if.ready <= !rsp_hold && ($urandom_range(0, 99) < 75);
    end
  end

  // Picks a name: mostly from a small pool so files get reused.
  function automatic logic [NAME_W-1:0] pick_name();
    if ($urandom_range(0, 9) < 8) return name_pool[$urandom_range(0, 5)];
    return {$urandom(), 8'($urandom())};
  endfunction

  function automatic logic [BLK_W-1:0] pick_block();
    int p;
    p = $urandom_range(0, 9);
    if (p < 6) return BLK_W'($urandom_range(RESERVED_BLOCKS + 1, RESERVED_BLOCKS + 40));
    if (p < 7) return '0;
    if (p < 8) return 8'hFF;
    return BLK_W'($urandom());
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    logic [NAME_W-1:0] nm;
    int                p;
    rst_ni = 1'b0;
    format_disk();
    name_pool[0] = 40'h4649_4C45_41;
    name_pool[1] = 40'h0;
    name_pool[2] = 40'hFF_FFFF_FFFF;
    name_pool[3] = 40'h8000_0000_01;
    name_pool[4] = 40'h5555_5555_55;
    name_pool[5] = 40'hAAAA_AAAA_AA;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: every operation, missing file, duplicate, empty file,
    // block outside the chain, remove with blocks, and a full directory.
    push_req(MODE_FIRST, name_pool[0], 8'd0);
    push_req(MODE_CREATE, name_pool[0], 8'd0);
    push_req(MODE_CREATE, name_pool[0], 8'd0);
    push_req(MODE_CHECK, name_pool[0], 8'd14);
    push_req(MODE_NEXT, name_pool[0], 8'd14);
    push_req(MODE_DELETE, name_pool[0], 8'd14);
    push_req(MODE_APPEND, name_pool[0], 8'd0);
    push_req(MODE_APPEND, name_pool[0], 8'd0);
    push_req(MODE_NEXT, name_pool[0], 8'd14);
    push_req(MODE_CHECK, name_pool[0], 8'd0);
    push_req(MODE_CHECK, name_pool[0], 8'd255);
    push_req(MODE_DELETE, name_pool[0], 8'd0);
    push_req(MODE_REMOVE, name_pool[0], 8'd0);
    push_req(MODE_DELETE, name_pool[0], 8'd14);
    push_req(MODE_FIRST, name_pool[0], 8'd0);
    push_req(MODE_REMOVE, name_pool[1], 8'd0);
    for (int i = 1; i <= ROOT_ENTRIES; i++) push_req(MODE_CREATE, name_pool[i % 6] ^ i, 8'd0);
    wait_drained();

    // The sender pauses until every result is in, then the receiver stalls
    // for a long stretch while requests keep coming.
    rsp_hold = 1'b1;
    for (int i = 0; i < 12; i++) push_req(MODE_FIRST, pick_name(), 8'd0);
    repeat (400) @(posedge clk_i);
    rsp_hold = 1'b0;
    wait_drained();

    // Random work over files from the pool. One long append burst drains
    // the free list so that a full disk is seen too.
    for (int k = 0; k < 1450; k++) begin
      p = $urandom_range(0, 99);
      nm = pick_name();
      if (p < 10) push_req(MODE_CREATE, nm, pick_block());
      else if (p < 17) push_req(MODE_REMOVE, nm, pick_block());
      else if (p < 45) push_req(MODE_APPEND, nm, pick_block());
      else if (p < 65) push_req(MODE_DELETE, nm, pick_block());
      else if (p < 77) push_req(MODE_CHECK, nm, pick_block());
      else if (p < 89) push_req(MODE_NEXT, nm, pick_block());
      else if (p < 97) push_req(MODE_FIRST, nm, pick_block());
      else push_req(mode_e'(3'd7), nm, pick_block());
      if (k == 700) begin
        wait_drained();
        for (int j = 0; j < 250; j++) push_req(MODE_APPEND, name_pool[j % 6], 8'd0);
      end
      if (pending_reqs.size() > 20) wait (pending_reqs.size() < 5);
    end
    wait_drained();
    repeat (NUM_BLOCKS + 20) @(posedge clk_i);
    if (mismatch_count == 0 && expected_rsps.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Generous watchdog: about 1750 items at worst-case latency and stalls.
  initial begin
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* fat_chain_block_allocator_top.f */
src/fatba_pkg.sv
src/fatba_if.sv
src/fatba_dir.sv
src/fat_chain_block_allocator_top.sv
verif/tb_fat_chain_block_allocator_top.sv
